/* hdl/dtslp_pkg.sv */
// Package for the DAG topological sort and longest path core.
// Holds shared sizes, the controller/datapath command and status structs.
// No dependencies.
package dtslp_pkg;

    localparam int MaxVertices = 32;
    localparam int MaxEdges    = 256;
    localparam int StackDepth  = MaxVertices + MaxEdges;
    localparam int VW          = 5;
    localparam int EAW         = 8;
    localparam int ECW         = 9;
    localparam int SAW         = 9;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_RUN = 1'b1;

    localparam logic KIND_ORDER = 1'b0;
    localparam logic KIND_PATH  = 1'b1;

    // Datapath operation selected by the controller.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_ADD_EDGE,
        DP_INIT,
        DP_PUSH_INIT,
        DP_TOP_READ,
        DP_TOP_EVAL,
        DP_SCAN_PUSH,
        DP_LEN_INIT,
        DP_LEN_SCAN,
        DP_LEN_STORE,
        DP_BEST_SCAN,
        DP_TRAIL_STEP,
        DP_EMIT,
        DP_FINISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_cmd;

    typedef struct packed {
        logic init_done;
        logic stack_empty;
        logic top_saved;
        logic scan_done;
        logic len_done;
        logic best_done;
        logic trail_done;
        logic emit_done;
    } t_status;

endpackage

/* hdl/dtslp_ctrl.sv */
// Controller state machine for the DAG topological sort and longest path core.
// Depends on dtslp_pkg.
module dtslp_ctrl import dtslp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_op,
    input  logic    i_emit_busy,
    input  t_status i_status,
    output logic    o_in_stall,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_READ,
        S_EVAL,
        S_SCAN,
        S_LINIT,
        S_LSCAN,
        S_LSTORE,
        S_BEST,
        S_TRAIL,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    t_dp_op w_op;

    // Next state and the command for the datapath.
    always_comb begin
        n_state = r_state;
        w_op    = DP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !i_emit_busy) begin
                    if (i_op == OP_ADD) begin
                        w_op = DP_ADD_EDGE;
                    end else begin
                        w_op    = DP_INIT;
                        n_state = S_PUSH;
                    end
                end
            end
            S_PUSH: begin
                w_op = DP_PUSH_INIT;
                if (i_status.init_done) n_state = S_READ;
            end
            S_READ: begin
                if (i_status.stack_empty) begin
                    n_state = S_LINIT;
                end else begin
                    w_op    = DP_TOP_READ;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                w_op = DP_TOP_EVAL;
                if (i_status.top_saved) n_state = S_READ;
                else n_state = S_SCAN;
            end
            S_SCAN: begin
                w_op = DP_SCAN_PUSH;
                if (i_status.scan_done) n_state = S_READ;
            end
            S_LINIT: begin
                w_op = DP_LEN_INIT;
                if (i_status.len_done) n_state = S_BEST;
                else n_state = S_LSCAN;
            end
            S_LSCAN: begin
                w_op = DP_LEN_SCAN;
                if (i_status.scan_done) n_state = S_LSTORE;
            end
            S_LSTORE: begin
                w_op    = DP_LEN_STORE;
                n_state = S_LINIT;
            end
            S_BEST: begin
                w_op = DP_BEST_SCAN;
                if (i_status.best_done) n_state = S_TRAIL;
            end
            S_TRAIL: begin
                w_op = DP_TRAIL_STEP;
                if (i_status.trail_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.emit_done) begin
                    w_op    = DP_FINISH;
                    n_state = S_IDLE;
                end else if (!i_emit_busy) begin
                    w_op = DP_EMIT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE) || i_emit_busy;
    assign o_cmd.op   = w_op;

endmodule

/* hdl/dtslp_dpath.sv */
// Datapath for the DAG topological sort and longest path core: edge store,
// walk stack, order and length tables, path trail and output register.
// Depends on dtslp_pkg.
module dtslp_dpath import dtslp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    input  logic [5:0]    i_vertex_count,
    input  logic [VW-1:0] i_from_vertex,
    input  logic [VW-1:0] i_to_vertex,
    input  logic          i_out_stall,
    output t_status       o_status,
    output logic          o_emit_busy,
    output logic          o_out_valid,
    output logic          o_kind,
    output logic [VW-1:0] o_vertex,
    output logic [VW-1:0] o_path_edges,
    output logic          o_overflow,
    output logic          o_last
);

    // Memories.
    logic [2*VW-1:0] r_edge_mem [MaxEdges];
    logic [VW-1:0]   r_stack_mem [StackDepth];

    // Small tables: r_plen and r_bpred are indexed by vertex, r_topo and r_trail by position.
    logic [VW-1:0] r_topo  [MaxVertices];
    logic [VW-1:0] r_plen  [MaxVertices];
    logic [VW-1:0] r_bpred [MaxVertices];
    logic [VW-1:0] r_trail [MaxVertices];

    logic [ECW-1:0]         r_edge_count;
    logic                   r_drop;
    logic [MaxVertices-1:0] r_visited, r_saved, r_pred_valid;
    logic [SAW-1:0]         r_sp;
    logic [VW:0]            r_tn, r_k, r_plen_cnt;
    logic [VW+1:0]          r_emit_idx;
    logic [ECW-1:0]         r_e;
    logic                   r_rd_pending;
    logic [2*VW-1:0]        r_edge_rd;
    logic [VW-1:0]          r_top;
    logic [VW-1:0]          r_v, r_len, r_best, r_cur, r_steps;
    logic [VW:0]            r_bi;
    logic                   r_trail_started;
    logic                   r_out_valid;
    logic                   r_kind, r_ovf, r_last;
    logic [VW-1:0]          r_vertex, r_pedges;

    logic [VW:0] w_n;
    always_comb begin
        if (i_vertex_count == 6'd0) w_n = 6'd1;
        else if (i_vertex_count > 6'(MaxVertices)) w_n = 6'(MaxVertices);
        else w_n = i_vertex_count;
    end

    // Fields of the edge read last cycle.
    logic [VW-1:0] w_et, w_ef;
    assign w_et = r_edge_rd[VW-1:0];
    assign w_ef = r_edge_rd[2*VW-1:VW];

    logic w_scan_last;
    assign w_scan_last = (r_e >= r_edge_count);

    logic [VW:0] w_cand;
    assign w_cand = {1'b0, r_plen[w_ef]} + 6'd1;
    logic [VW-1:0] w_cand_sat;
    assign w_cand_sat = (w_cand > 6'd31) ? 5'd31 : w_cand[VW-1:0];

    logic w_emit_total_done;
    logic [VW+1:0] w_total;
    assign w_total = {1'b0, r_tn} + {1'b0, r_plen_cnt};
    assign w_emit_total_done = (r_emit_idx >= w_total);

    // Edge store and stack are written here; read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_ADD_EDGE && i_from_vertex < w_n && i_to_vertex < w_n
            && r_edge_count < ECW'(MaxEdges)) begin
            r_edge_mem[r_edge_count[EAW-1:0]] <= {i_from_vertex, i_to_vertex};
        end
        r_edge_rd <= r_edge_mem[r_e[EAW-1:0]];
        r_top     <= r_stack_mem[r_sp - SAW'(1)];
        if (i_cmd.op == DP_PUSH_INIT) begin
            r_stack_mem[r_sp] <= r_k[VW-1:0];
        end else if (i_cmd.op == DP_SCAN_PUSH && r_rd_pending && w_et == r_v
                     && {1'b0, w_ef} < w_n && r_sp < SAW'(StackDepth)) begin
            r_stack_mem[r_sp] <= w_ef;
        end
    end

    // Control registers of the datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_count <= '0;
            r_drop       <= 1'b0;
            r_visited    <= '0;
            r_saved      <= '0;
            r_sp         <= '0;
            r_out_valid  <= 1'b0;
            r_tn         <= '0;
            r_k          <= '0;
            r_e          <= '0;
            r_rd_pending <= 1'b0;
            r_emit_idx   <= '0;
            r_plen_cnt   <= '0;
            r_trail_started <= 1'b0;
            r_bi         <= '0;
        end else begin
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            case (i_cmd.op)
                DP_ADD_EDGE: begin
                    if (i_from_vertex < w_n && i_to_vertex < w_n
                        && r_edge_count < ECW'(MaxEdges)) begin
                        r_edge_count <= r_edge_count + ECW'(1);
                    end else begin
                        r_drop <= 1'b1;
                    end
                end
                DP_INIT: begin
                    r_visited    <= '0;
                    r_saved      <= '0;
                    r_pred_valid <= '0;
                    r_sp         <= '0;
                    r_tn         <= '0;
                    r_k          <= '0;
                end
                DP_PUSH_INIT: begin
                    r_sp <= r_sp + SAW'(1);
                    r_k  <= r_k + 6'd1;
                end
                DP_TOP_READ: begin
                    // The length pass starts from the first emitted vertex.
                    r_k          <= '0;
                    r_e          <= '0;
                    r_rd_pending <= 1'b0;
                end
                DP_TOP_EVAL: begin
                    r_v <= r_top;
                    if (r_saved[r_top]) begin
                        r_sp <= r_sp - SAW'(1);
                    end else if (r_visited[r_top]) begin
                        r_saved[r_top] <= 1'b1;
                        r_topo[r_tn[VW-1:0]] <= r_top;
                        r_tn <= r_tn + 6'd1;
                        r_sp <= r_sp - SAW'(1);
                    end else begin
                        r_visited[r_top] <= 1'b1;
                    end
                end
                DP_SCAN_PUSH: begin
                    // One edge fetch in flight; evaluate the previous one.
                    if (r_rd_pending && w_et == r_v && {1'b0, w_ef} < w_n
                        && r_sp < SAW'(StackDepth)) begin
                        r_sp <= r_sp + SAW'(1);
                    end
                    r_rd_pending <= !w_scan_last;
                    if (!w_scan_last) r_e <= r_e + ECW'(1);
                end
                DP_LEN_INIT: begin
                    if (r_k == 6'd0) begin
                        for (int i = 0; i < MaxVertices; i++) begin
                            r_plen[i]  <= '0;
                            r_bpred[i] <= '0;
                        end
                    end
                    r_v          <= r_topo[r_k[VW-1:0]];
                    r_len        <= '0;
                    r_e          <= '0;
                    r_rd_pending <= 1'b0;
                    r_bi         <= 6'd1;
                    r_best       <= '0;
                end
                DP_LEN_SCAN: begin
                    if (r_rd_pending && w_et == r_v && {1'b0, w_ef} < w_n
                        && w_cand_sat >= r_len) begin
                        r_len            <= w_cand_sat;
                        r_bpred[r_v]     <= w_ef;
                        r_pred_valid[r_v] <= 1'b1;
                    end
                    r_rd_pending <= !w_scan_last;
                    if (!w_scan_last) r_e <= r_e + ECW'(1);
                end
                DP_LEN_STORE: begin
                    r_plen[r_v] <= r_len;
                    r_k         <= r_k + 6'd1;
                end
                DP_BEST_SCAN: begin
                    if (r_bi < w_n) begin
                        if (r_plen[r_bi[VW-1:0]] > r_plen[r_best]) r_best <= r_bi[VW-1:0];
                        r_bi <= r_bi + 6'd1;
                    end
                    r_trail_started <= 1'b0;
                end
                DP_TRAIL_STEP: begin
                    if (!r_trail_started) begin
                        r_trail_started <= 1'b1;
                        r_cur      <= r_best;
                        r_trail[0] <= r_best;
                        r_plen_cnt <= 6'd1;
                        r_steps    <= r_plen[r_best];
                    end else if (r_steps != '0 && r_pred_valid[r_cur]
                                 && r_plen_cnt < 6'(MaxVertices)
                                 && {1'b0, r_bpred[r_cur]} < w_n) begin
                        r_cur <= r_bpred[r_cur];
                        r_trail[r_plen_cnt[VW-1:0]] <= r_bpred[r_cur];
                        r_plen_cnt <= r_plen_cnt + 6'd1;
                        r_steps    <= r_steps - 5'd1;
                    end else begin
                        r_steps <= '0;
                    end
                    r_emit_idx <= '0;
                end
                DP_EMIT: begin
                    // Nothing is loaded once every entry has gone out.
                    if (!w_emit_total_done) begin
                        r_out_valid <= 1'b1;
                        r_ovf       <= r_drop;
                        if (r_emit_idx < {1'b0, r_tn}) begin
                            r_kind   <= KIND_ORDER;
                            r_vertex <= r_topo[r_emit_idx[VW-1:0]];
                            r_pedges <= '0;
                            r_last   <= 1'b0;
                        end else begin
                            r_kind   <= KIND_PATH;
                            r_vertex <= r_trail[5'(w_total - r_emit_idx - 7'd1)];
                            r_pedges <= 5'(r_plen_cnt - 6'd1);
                            r_last   <= (r_emit_idx == w_total - 7'd1);
                        end
                        r_emit_idx <= r_emit_idx + 7'd1;
                    end
                end
                DP_FINISH: begin
                    r_edge_count <= '0;
                    r_drop       <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_status.init_done   = (r_k == w_n - 6'd1) && i_cmd.op == DP_PUSH_INIT;
    assign o_status.stack_empty = (r_sp == '0);
    assign o_status.top_saved   = r_saved[r_top] || r_visited[r_top];
    assign o_status.scan_done   = w_scan_last && r_rd_pending == 1'b0 && r_e != '0
                                  || (r_edge_count == '0);
    assign o_status.len_done    = (r_k >= r_tn);
    assign o_status.best_done   = (r_bi >= w_n);
    assign o_status.trail_done  = r_trail_started && r_steps == '0;
    assign o_status.emit_done   = w_emit_total_done && !r_out_valid;

    assign o_emit_busy  = r_out_valid && i_out_stall;
    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_vertex     = r_vertex;
    assign o_path_edges = r_pedges;
    assign o_overflow   = r_ovf;
    assign o_last       = r_last;

endmodule

/* hdl/dag_topo_sort_longest_path_core.sv */
// Top level of the DAG topological sort and longest path core.
// Depends on dtslp_pkg, dtslp_ctrl and dtslp_dpath.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------------------
//  input    | i_in_valid / o_in_stall   | i_op, i_from_vertex, i_to_vertex
//  output   | o_out_valid / i_out_stall | o_kind, o_vertex, o_path_edges, o_overflow, o_last
//  config   | i_cfg_we                  | i_cfg_data (vertex count)
//
// A run over n vertices and E stored edges first pushes every vertex, then walks
// the graph; every newly visited vertex scans the whole edge store through the
// one memory read port, and so does every vertex in the path length pass. The run
// then searches for the path end, builds the trail and emits the order and the
// path with its number of edges.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled output holds its transaction; the input stalls during a run.
module dag_topo_sort_longest_path_core import dtslp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [5:0]    i_cfg_data,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_op,
    input  logic [VW-1:0] i_from_vertex,
    input  logic [VW-1:0] i_to_vertex,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic          o_kind,
    output logic [VW-1:0] o_vertex,
    output logic [VW-1:0] o_path_edges,
    output logic          o_overflow,
    output logic          o_last
);

    logic [5:0] r_vertex_count;
    t_cmd       w_cmd;
    t_status    w_status;
    logic       w_emit_busy;

    // Vertex count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= 6'd1;
        end else if (i_cfg_we) begin
            r_vertex_count <= i_cfg_data;
        end
    end

    dtslp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_op),
        .i_emit_busy (w_emit_busy),
        .i_status    (w_status),
        .o_in_stall  (o_in_stall),
        .o_cmd       (w_cmd)
    );

    dtslp_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_vertex_count (r_vertex_count),
        .i_from_vertex  (i_from_vertex),
        .i_to_vertex    (i_to_vertex),
        .i_out_stall    (i_out_stall),
        .o_status       (w_status),
        .o_emit_busy    (w_emit_busy),
        .o_out_valid    (o_out_valid),
        .o_kind         (o_kind),
        .o_vertex       (o_vertex),
        .o_path_edges   (o_path_edges),
        .o_overflow     (o_overflow),
        .o_last         (o_last)
    );

    // The input is never taken while a result waits on a stalled output.
    a_no_accept_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input accepted while output stalled");

    // Order entries carry no path length and never end a run.
    a_order_no_edges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_ORDER) |-> (o_path_edges == '0 && !o_last))
        else $error("order entry carries path data");

    // The final entry of a run is always a path entry.
    a_last_is_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> (o_kind == KIND_PATH))
        else $error("last flag on an order entry");

endmodule
